FILE: src/ttb_pkg.sv
// ttb_pkg: shared types and constants for the triangle tangent basis core
// no dependencies; imported by triangle_tangent_basis_core
package ttb_pkg;

    // field widths
    localparam int IDX_W = 10;
    localparam int CRD_W = 32;
    localparam int VEC_W = 16;

    // datapath widths
    localparam int D_W   = 33;  // coordinate difference
    localparam int P_W   = 66;  // product of two differences
    localparam int V_W   = 67;  // difference of two products
    localparam int M_W   = 30;  // normalized magnitude
    localparam int SQ_W  = 64;  // square root working width
    localparam int LEN_W = 32;  // vector length
    localparam int Q_W   = 15;  // quotient bits
    localparam int NUM_W = 46;  // division remainder

    // action codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_TRI    = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_DEGEN  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_NOVERT = 2'd3;

    localparam logic signed [VEC_W-1:0] Q14_ONE = 16'sd16384;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [CRD_W-1:0] pos_x;
        logic signed [CRD_W-1:0] pos_y;
        logic signed [CRD_W-1:0] pos_z;
        logic signed [CRD_W-1:0] tex_s;
        logic signed [CRD_W-1:0] tex_t;
        logic [IDX_W-1:0]        vertex_a;
        logic [IDX_W-1:0]        vertex_b;
        logic [IDX_W-1:0]        vertex_c;
    } ttb_cmd_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] tangent_x;
        logic signed [VEC_W-1:0] tangent_y;
        logic signed [VEC_W-1:0] tangent_z;
        logic signed [VEC_W-1:0] bitangent_x;
        logic signed [VEC_W-1:0] bitangent_y;
        logic signed [VEC_W-1:0] bitangent_z;
        logic [IDX_W-1:0]        vertex_index;
        logic [1:0]              status;
    } ttb_rsp_t;

endpackage

FILE: src/ttb_ram.sv
// ttb_ram: generic single write port, single read port ram, registered read
// no dependencies
module ttb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/triangle_tangent_basis_core.sv
// triangle_tangent_basis_core: vertex store with tangent and bitangent solver
// depends on ttb_pkg and ttb_ram
//
// Usage: a command transfer happens at a rising edge with start high and busy
// low; cmd carries action, position, texture coordinate and vertex indexes.
// Every command gives exactly one result on rsp, valid for the single cycle
// in which done is high; the receiver cannot stall, so nothing is held back.
// Steps of each action:
//   add_vertex, unused action, rejected index: answered straight from idle
//   read_vertex: one registered ram read of the tangent store
//   make_triangle: the vertex reads, then the 14 products on the one shared
//   33x33 multiplier, then per vector a magnitude alignment by shift steps,
//   the squares, a bit-serial square root and a restoring divide per
//   component, and finally the write-back of the three vertices. busy stays
//   high for the whole command, so a new command is taken only after the
//   last one is done.
// Reset clears the vertex count and the controller; the stores need no
// clearing since an entry is never read before it has been added.
module triangle_tangent_basis_core
    import ttb_pkg::*;
#(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ttb_cmd_t cmd,
    output logic     busy,
    output logic     done,
    output ttb_rsp_t rsp
);

    localparam int CNT_W  = $clog2(VERTEX_DEPTH + 1);
    localparam int ADDR_W = $clog2(VERTEX_DEPTH);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int POS_W  = 5 * CRD_W;
    localparam int TB_W   = 6 * VEC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_LD0, S_LD1, S_LD2, S_LD3, S_MUL, S_ACC,
        S_LOAD, S_SHIFT, S_SQRT, S_DIVINIT, S_DIV, S_WB
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] va_reg, vb_reg, vc_reg;
    logic [3:0]       step_reg;
    logic             sq_reg;
    logic             vec_reg;
    logic [1:0]       comp_reg;
    logic [1:0]       wb_reg;
    logic             done_reg;
    ttb_rsp_t         rsp_reg;

    logic signed [CRD_W-1:0] p0_reg [5];
    logic signed [D_W-1:0]   e0_reg [3];
    logic signed [D_W-1:0]   e1_reg [3];
    logic signed [D_W-1:0]   ds0_reg, dt0_reg, ds1_reg, dt1_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [V_W-1:0]   acc_reg;
    logic signed [V_W-1:0]   det_reg;
    logic signed [V_W-1:0]   tv_reg [3];
    logic signed [V_W-1:0]   bv_reg [3];
    logic [V_W-1:0]          mag_reg [3];
    logic                    neg_reg [3];
    logic [SQ_W-1:0]         sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [NUM_W-1:0]        div_rem_reg, div_dsr_reg;
    logic [Q_W-1:0]          quo_reg;
    logic [3:0]              div_cnt_reg;
    logic signed [VEC_W-1:0] tn_reg [3];
    logic signed [VEC_W-1:0] bn_reg [3];

    // handshake
    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // index range checks against the fill count
    logic [CMP_W-1:0] cnt_ext, ca_ext, cb_ext, cc_ext;
    logic [CMP_W-1:0] va_ext, vb_ext, vc_ext;
    logic             full, miss_a, miss_tri;
    assign cnt_ext  = CMP_W'(count_reg);
    assign ca_ext   = CMP_W'(cmd.vertex_a);
    assign cb_ext   = CMP_W'(cmd.vertex_b);
    assign cc_ext   = CMP_W'(cmd.vertex_c);
    assign va_ext   = CMP_W'(va_reg);
    assign vb_ext   = CMP_W'(vb_reg);
    assign vc_ext   = CMP_W'(vc_reg);
    assign full     = (count_reg == CNT_W'(VERTEX_DEPTH));
    assign miss_a   = (ca_ext >= cnt_ext);
    assign miss_tri = miss_a || (cb_ext >= cnt_ext) || (cc_ext >= cnt_ext);

    // result with zero vectors, a status and an index
    function automatic ttb_rsp_t status_rsp(input logic [1:0] st,
                                            input logic [IDX_W-1:0] idx);
        ttb_rsp_t r;
        r = '0;
        r.vertex_index = idx;
        r.status = st;
        return r;
    endfunction

    // result of a stored vertex
    ttb_rsp_t add_rsp;
    always_comb
    begin
        add_rsp             = status_rsp(STAT_OK, cnt_ext[IDX_W-1:0]);
        add_rsp.tangent_z   = Q14_ONE;
        add_rsp.bitangent_z = Q14_ONE;
    end

    // position and texture store
    logic              pos_we;
    logic [ADDR_W-1:0] pos_raddr;
    logic [POS_W-1:0]  pos_rdata;
    assign pos_we = accept && (cmd.action == ACT_ADD) && !full;

    always_comb
    begin
        case (state_reg)
            S_LD0:   pos_raddr = va_ext[ADDR_W-1:0];
            S_LD1:   pos_raddr = vb_ext[ADDR_W-1:0];
            default: pos_raddr = vc_ext[ADDR_W-1:0];
        endcase
    end

    ttb_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (cnt_ext[ADDR_W-1:0]),
        .wdata ({cmd.tex_t, cmd.tex_s, cmd.pos_z, cmd.pos_y, cmd.pos_x}),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // tangent and bitangent store, tangent in the low half
    logic              tb_we;
    logic [ADDR_W-1:0] tb_waddr;
    logic [TB_W-1:0]   tb_wdata;
    logic [TB_W-1:0]   tb_rdata;

    always_comb
    begin
        tb_we    = pos_we;
        tb_waddr = cnt_ext[ADDR_W-1:0];
        tb_wdata = {Q14_ONE, 16'sd0, 16'sd0, Q14_ONE, 16'sd0, 16'sd0};
        if (state_reg == S_WB)
        begin
            tb_we    = 1'b1;
            tb_wdata = {bn_reg[2], bn_reg[1], bn_reg[0], tn_reg[2], tn_reg[1], tn_reg[0]};
            case (wb_reg)
                2'd0:    tb_waddr = va_ext[ADDR_W-1:0];
                2'd1:    tb_waddr = vb_ext[ADDR_W-1:0];
                default: tb_waddr = vc_ext[ADDR_W-1:0];
            endcase
        end
    end

    ttb_ram #(.WIDTH(TB_W), .DEPTH(VERTEX_DEPTH)) u_tb_ram (
        .clk   (clk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (tb_wdata),
        .raddr (va_ext[ADDR_W-1:0]),
        .rdata (tb_rdata)
    );

    // shared multiplier operand select
    logic signed [D_W-1:0] mul_a, mul_b;
    logic signed [P_W-1:0] prod_c;
    logic [M_W-1:0]        sq_op;
    assign sq_op = mag_reg[step_reg[1:0]][M_W-1:0];

    always_comb
    begin
        mul_a = ds0_reg;
        mul_b = dt1_reg;
        if (sq_reg)
        begin
            mul_a = {3'b000, sq_op};
            mul_b = {3'b000, sq_op};
        end
        else
        begin
            case (step_reg)
                4'd0:    begin mul_a = ds0_reg; mul_b = dt1_reg;   end
                4'd1:    begin mul_a = ds1_reg; mul_b = dt0_reg;   end
                4'd2:    begin mul_a = dt1_reg; mul_b = e0_reg[0]; end
                4'd3:    begin mul_a = dt0_reg; mul_b = e1_reg[0]; end
                4'd4:    begin mul_a = dt1_reg; mul_b = e0_reg[1]; end
                4'd5:    begin mul_a = dt0_reg; mul_b = e1_reg[1]; end
                4'd6:    begin mul_a = dt1_reg; mul_b = e0_reg[2]; end
                4'd7:    begin mul_a = dt0_reg; mul_b = e1_reg[2]; end
                4'd8:    begin mul_a = ds0_reg; mul_b = e1_reg[0]; end
                4'd9:    begin mul_a = ds1_reg; mul_b = e0_reg[0]; end
                4'd10:   begin mul_a = ds0_reg; mul_b = e1_reg[1]; end
                4'd11:   begin mul_a = ds1_reg; mul_b = e0_reg[1]; end
                4'd12:   begin mul_a = ds0_reg; mul_b = e1_reg[2]; end
                4'd13:   begin mul_a = ds1_reg; mul_b = e0_reg[2]; end
                default: begin mul_a = ds0_reg; mul_b = dt1_reg;   end
            endcase
        end
    end

    assign prod_c = mul_a * mul_b;

    // accumulator results
    logic signed [V_W-1:0] prod_ext, diff_c, sqsum_c;
    assign prod_ext = {prod_reg[P_W-1], prod_reg};
    assign diff_c   = acc_reg - prod_ext;
    assign sqsum_c  = ((step_reg == 4'd0) ? '0 : acc_reg) + prod_ext;

    // magnitudes of the vector being normalized
    logic [V_W-1:0] src_mag [3];
    logic           src_neg [3];
    logic [V_W-1:0] src_or, mag_or;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [V_W-1:0] src;
            src        = vec_reg ? bv_reg[i] : tv_reg[i];
            src_mag[i] = src[V_W-1] ? V_W'(-src) : V_W'(src);
            src_neg[i] = src[V_W-1] ^ det_reg[V_W-1];
        end
    end
    assign src_or = src_mag[0] | src_mag[1] | src_mag[2];
    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // square root step
    logic [SQ_W-1:0] sq_trial, sq_res_nx;
    logic            sq_ge;
    assign sq_trial  = sq_res_reg + sq_bit_reg;
    assign sq_ge     = (sq_rem_reg >= sq_trial);
    assign sq_res_nx = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

    // restoring divide step and rounded component
    logic                    div_ge;
    logic [Q_W-1:0]          q_fin;
    logic signed [VEC_W-1:0] cval, comp_c;
    assign div_ge = (div_rem_reg >= div_dsr_reg);
    assign q_fin  = {quo_reg[Q_W-2:0], div_ge};
    assign cval   = {1'b0, q_fin};
    assign comp_c = neg_reg[comp_reg] ? -cval : cval;

    // sequencer with datapath registers and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            va_reg      <= '0;
            vb_reg      <= '0;
            vc_reg      <= '0;
            step_reg    <= '0;
            sq_reg      <= 1'b0;
            vec_reg     <= 1'b0;
            comp_reg    <= '0;
            wb_reg      <= '0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
            ds0_reg     <= '0;
            dt0_reg     <= '0;
            ds1_reg     <= '0;
            dt1_reg     <= '0;
            prod_reg    <= '0;
            acc_reg     <= '0;
            det_reg     <= '0;
            sq_rem_reg  <= '0;
            sq_res_reg  <= '0;
            sq_bit_reg  <= '0;
            len_reg     <= '0;
            div_rem_reg <= '0;
            div_dsr_reg <= '0;
            quo_reg     <= '0;
            div_cnt_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                p0_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i]  <= '0;
                e1_reg[i]  <= '0;
                tv_reg[i]  <= '0;
                bv_reg[i]  <= '0;
                mag_reg[i] <= '0;
                neg_reg[i] <= 1'b0;
                tn_reg[i]  <= '0;
                bn_reg[i]  <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        va_reg  <= cmd.vertex_a;
                        vb_reg  <= cmd.vertex_b;
                        vc_reg  <= cmd.vertex_c;
                        case (cmd.action)
                            ACT_ADD:
                            begin
                                done_reg <= 1'b1;
                                if (full)
                                begin
                                    rsp_reg <= status_rsp(STAT_FULL, '0);
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    rsp_reg   <= add_rsp;
                                end
                            end
                            ACT_TRI:
                            begin
                                if (miss_tri)
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= status_rsp(STAT_NOVERT, cmd.vertex_a);
                                end
                                else
                                begin
                                    state_reg <= S_LD0;
                                end
                            end
                            ACT_READ:
                            begin
                                if (miss_a)
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= status_rsp(STAT_NOVERT, cmd.vertex_a);
                                end
                                else
                                begin
                                    state_reg <= S_RD0;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                                rsp_reg  <= '0;
                            end
                        endcase
                    end
                end

                // stored vector read
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    done_reg             <= 1'b1;
                    rsp_reg.tangent_x    <= tb_rdata[15:0];
                    rsp_reg.tangent_y    <= tb_rdata[31:16];
                    rsp_reg.tangent_z    <= tb_rdata[47:32];
                    rsp_reg.bitangent_x  <= tb_rdata[63:48];
                    rsp_reg.bitangent_y  <= tb_rdata[79:64];
                    rsp_reg.bitangent_z  <= tb_rdata[95:80];
                    rsp_reg.vertex_index <= va_reg;
                    rsp_reg.status       <= STAT_OK;
                    state_reg            <= S_IDLE;
                end

                // fetch the three vertices and form the deltas
                S_LD0:
                begin
                    state_reg <= S_LD1;
                end
                S_LD1:
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        p0_reg[i] <= pos_rdata[i*CRD_W +: CRD_W];
                    end
                    state_reg <= S_LD2;
                end
                S_LD2:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e0_reg[i] <= {pos_rdata[i*CRD_W+CRD_W-1], pos_rdata[i*CRD_W +: CRD_W]}
                                     - {p0_reg[i][CRD_W-1], p0_reg[i]};
                    end
                    ds0_reg   <= {pos_rdata[127], pos_rdata[127:96]} - {p0_reg[3][31], p0_reg[3]};
                    dt0_reg   <= {pos_rdata[159], pos_rdata[159:128]} - {p0_reg[4][31], p0_reg[4]};
                    state_reg <= S_LD3;
                end
                S_LD3:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= {pos_rdata[i*CRD_W+CRD_W-1], pos_rdata[i*CRD_W +: CRD_W]}
                                     - {p0_reg[i][CRD_W-1], p0_reg[i]};
                    end
                    ds1_reg   <= {pos_rdata[127], pos_rdata[127:96]} - {p0_reg[3][31], p0_reg[3]};
                    dt1_reg   <= {pos_rdata[159], pos_rdata[159:128]} - {p0_reg[4][31], p0_reg[4]};
                    step_reg  <= '0;
                    sq_reg    <= 1'b0;
                    vec_reg   <= 1'b0;
                    state_reg <= S_MUL;
                end

                // shared multiplier
                S_MUL:
                begin
                    prod_reg  <= prod_c;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (sq_reg)
                    begin
                        acc_reg <= sqsum_c;
                        if (step_reg == 4'd2)
                        begin
                            sq_rem_reg <= sqsum_c[SQ_W-1:0];
                            sq_res_reg <= '0;
                            sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
                            state_reg  <= S_SQRT;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        if (!step_reg[0])
                        begin
                            acc_reg <= prod_ext;
                        end
                        else
                        begin
                            case (step_reg)
                                4'd1:    det_reg   <= diff_c;
                                4'd3:    tv_reg[0] <= diff_c;
                                4'd5:    tv_reg[1] <= diff_c;
                                4'd7:    tv_reg[2] <= diff_c;
                                4'd9:    bv_reg[0] <= diff_c;
                                4'd11:   bv_reg[1] <= diff_c;
                                default: bv_reg[2] <= diff_c;
                            endcase
                        end
                        if (step_reg == 4'd13)
                        begin
                            if (det_reg == '0)
                            begin
                                done_reg  <= 1'b1;
                                rsp_reg   <= status_rsp(STAT_DEGEN, va_reg);
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_LOAD;
                            end
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end

                // magnitudes and signs of the vector
                S_LOAD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= src_mag[i];
                        neg_reg[i] <= src_neg[i];
                    end
                    if (src_or == '0)
                    begin
                        done_reg  <= 1'b1;
                        rsp_reg   <= status_rsp(STAT_DEGEN, va_reg);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT;
                    end
                end

                // align the largest magnitude into [2^29, 2^30)
                S_SHIFT:
                begin
                    if (|mag_or[V_W-1:33])
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 4;
                    end
                    else if (|mag_or[32:30])
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!(|mag_or[29:25]))
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 4;
                    end
                    else if (!mag_or[29])
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end
                    else
                    begin
                        sq_reg    <= 1'b1;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end

                // bit-serial integer square root
                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_rem_reg <= sq_rem_reg - sq_trial;
                    end
                    sq_res_reg <= sq_res_nx;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                    begin
                        len_reg   <= sq_res_nx[LEN_W-1:0];
                        comp_reg  <= '0;
                        state_reg <= S_DIVINIT;
                    end
                end

                // rounded division of each component by the length
                S_DIVINIT:
                begin
                    div_rem_reg <= {2'b00, mag_reg[comp_reg][M_W-1:0], 14'd0}
                                   + NUM_W'(len_reg >> 1);
                    div_dsr_reg <= {len_reg, 14'd0};
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_ge)
                    begin
                        div_rem_reg <= div_rem_reg - div_dsr_reg;
                    end
                    quo_reg     <= q_fin;
                    div_dsr_reg <= div_dsr_reg >> 1;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 4'(Q_W - 1))
                    begin
                        if (vec_reg)
                        begin
                            bn_reg[comp_reg] <= comp_c;
                        end
                        else
                        begin
                            tn_reg[comp_reg] <= comp_c;
                        end
                        if (comp_reg == 2'd2)
                        begin
                            if (!vec_reg)
                            begin
                                vec_reg   <= 1'b1;
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                wb_reg    <= '0;
                                state_reg <= S_WB;
                            end
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= S_DIVINIT;
                        end
                    end
                end

                // write both vectors to the three vertices
                S_WB:
                begin
                    wb_reg <= wb_reg + 1'b1;
                    if (wb_reg == 2'd2)
                    begin
                        done_reg             <= 1'b1;
                        rsp_reg.tangent_x    <= tn_reg[0];
                        rsp_reg.tangent_y    <= tn_reg[1];
                        rsp_reg.tangent_z    <= tn_reg[2];
                        rsp_reg.bitangent_x  <= bn_reg[0];
                        rsp_reg.bitangent_y  <= bn_reg[1];
                        rsp_reg.bitangent_z  <= bn_reg[2];
                        rsp_reg.vertex_index <= va_reg;
                        rsp_reg.status       <= STAT_OK;
                        state_reg            <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a result only follows a transfer or a command in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without a command");

    // fill count never passes the store depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VERTEX_DEPTH))
        else $error("vertex count out of range");

    // store full is only reported when the store really is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_FULL) |-> (count_reg == CNT_W'(VERTEX_DEPTH)))
        else $error("store full reported with free entries");

    // a triangle write-back only starts from a nonzero determinant
    a_wb_det: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (det_reg != '0))
        else $error("write-back with zero determinant");

endmodule
